[src/tla_pkg.sv]
`timescale 1ns / 1ps

package tla_pkg;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_on;
        logic       eol_mark;
        logic       tab_caret;
        logic       ctrl_visible;
    } t_cfg;

    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [2:0] REG_NUMBER_MODE  = 3'd0;
    localparam logic [2:0] REG_SQUEEZE      = 3'd1;
    localparam logic [2:0] REG_EOL_MARK     = 3'd2;
    localparam logic [2:0] REG_TAB_CARET    = 3'd3;
    localparam logic [2:0] REG_CTRL_VISIBLE = 3'd4;

    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    localparam int unsigned MIN_NUM_WIDTH = 6;
    localparam int unsigned MAX_CHAR_OUT  = 4;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_CTRL_END = 8'h20;

endpackage

[src/tla_cfg_regs.sv]
`timescale 1ns / 1ps

module tla_cfg_regs
    import tla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[CFG_ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_NUMBER_MODE:  r_cfg.number_mode  <= pwdata[1:0];
                REG_SQUEEZE:      r_cfg.squeeze_on   <= pwdata[0];
                REG_EOL_MARK:     r_cfg.eol_mark     <= pwdata[0];
                REG_TAB_CARET:    r_cfg.tab_caret    <= pwdata[0];
                REG_CTRL_VISIBLE: r_cfg.ctrl_visible <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_NUMBER_MODE:  prdata = {{(CFG_DATA_W-2){1'b0}}, r_cfg.number_mode};
            REG_SQUEEZE:      prdata = {{(CFG_DATA_W-1){1'b0}}, r_cfg.squeeze_on};
            REG_EOL_MARK:     prdata = {{(CFG_DATA_W-1){1'b0}}, r_cfg.eol_mark};
            REG_TAB_CARET:    prdata = {{(CFG_DATA_W-1){1'b0}}, r_cfg.tab_caret};
            REG_CTRL_VISIBLE: prdata = {{(CFG_DATA_W-1){1'b0}}, r_cfg.ctrl_visible};
            default:          prdata = '0;
        endcase
    end

endmodule

[src/tla_bcd_counter.sv]
`timescale 1ns / 1ps

module tla_bcd_counter
    import tla_pkg::*;
#(
    parameter int unsigned NUMBER_DIGITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_inc,
    output logic [NUMBER_DIGITS*4-1:0] o_next_digits
);

    logic [NUMBER_DIGITS*4-1:0] r_digits;
    logic [NUMBER_DIGITS*4-1:0] n_digits;
    logic [NUMBER_DIGITS:0]     w_carry;

    // saturates at all nines
    always_comb begin
        w_carry[0] = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            w_carry[i+1] = w_carry[i] && (r_digits[i*4 +: 4] == 4'd9);
        end
        n_digits = r_digits;
        if (i_inc && !w_carry[NUMBER_DIGITS]) begin
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
                if (w_carry[i]) begin
                    n_digits[i*4 +: 4] = (r_digits[i*4 +: 4] == 4'd9) ? 4'd0
                                       : r_digits[i*4 +: 4] + 4'd1;
                end
            end
        end
    end

    assign o_next_digits = n_digits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits <= '0;
        end else begin
            r_digits <= n_digits;
        end
    end

endmodule

[src/text_line_annotator_top.sv]
`timescale 1ns / 1ps
// The first output byte of an item is presented in the cycle after it is accepted.
// Throughput: one item per cycle while each item yields one byte and output is ready;
// an item of N bytes (up to NUMBER_DIGITS + 6) holds the serializer until all are taken.
// Reset (i_rst_n low, synchronous): registers, line counter and line state cleared,
// output serializer empty.

module text_line_annotator_top
    import tla_pkg::*;
#(
    parameter int unsigned NUMBER_DIGITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,  // [7:0] data_byte
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,  // [7:0] out_byte
    output logic                  o_m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned MAX_OUT = NUMBER_DIGITS + 2 + MAX_CHAR_OUT;
    localparam int unsigned IW      = $clog2(MAX_OUT);
    localparam int unsigned PW      = $clog2(MAX_OUT + 1);
    localparam int unsigned SW      = $clog2(NUMBER_DIGITS + 1);

    t_cfg w_cfg;

    logic [7:0]          r_buf [MAX_OUT];
    logic [7:0]          n_buf [MAX_OUT];
    logic [PW-1:0]       r_pos;
    logic [PW-1:0]       n_pos;
    logic [PW-1:0]       r_end;
    logic [PW-1:0]       n_end;
    logic                r_busy;
    logic                r_at_begin;
    logic                r_blank_seen;

    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_last;
    logic                w_blank;
    logic                w_drop;
    logic                w_numbered;
    logic                w_load;
    logic [7:0]          w_c;
    logic [7:0]          w_c7;
    logic [7:0]          w_ch [MAX_CHAR_OUT];
    logic [2:0]          w_nch;
    logic [7:0]          w_lo0;
    logic [7:0]          w_lo1;
    logic [1:0]          w_nlo;
    logic [NUMBER_DIGITS*4-1:0] w_digits;
    logic [NUMBER_DIGITS-1:0]   w_shown;
    logic [SW-1:0]       w_sig;

    tla_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tla_bcd_counter #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_counter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_inc         (w_in_acc && w_numbered),
        .o_next_digits (w_digits)
    );

    assign w_c       = i_s_axis_tdata;
    assign w_last    = (r_pos + PW'(1)) == r_end;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = !r_busy || (i_m_axis_tready && w_last);
    assign o_m_axis_tvalid = r_busy;
    assign o_m_axis_tdata  = r_buf[r_pos[IW-1:0]];
    assign o_m_axis_tlast  = w_last;

    assign w_blank    = (w_c == CH_LF);
    assign w_drop     = r_at_begin && w_cfg.squeeze_on && w_blank && r_blank_seen;
    assign w_numbered = r_at_begin && !w_drop
                        && ((w_cfg.number_mode == NUM_ALL)
                        || ((w_cfg.number_mode == NUM_NONBLANK) && !w_blank));
    assign w_load     = w_in_acc && !w_drop;

    // caret notation of the low seven bits
    always_comb begin
        w_c7 = {1'b0, w_c[6:0]};
        if (w_c7 == CH_DEL) begin
            w_lo0 = CH_CARET;
            w_lo1 = CH_QMARK;
            w_nlo = 2'd2;
        end else if (w_c7 < CH_CTRL_END) begin
            w_lo0 = CH_CARET;
            w_lo1 = w_c7 + CH_AT;
            w_nlo = 2'd2;
        end else begin
            w_lo0 = w_c7;
            w_lo1 = CH_SPACE;
            w_nlo = 2'd1;
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_CHAR_OUT; k++) begin
            w_ch[k] = CH_SPACE;
        end
        w_nch = 3'd1;
        priority if (w_c == CH_LF) begin
            if (w_cfg.eol_mark) begin
                w_ch[0] = CH_DOLLAR;
                w_ch[1] = CH_LF;
                w_nch   = 3'd2;
            end else begin
                w_ch[0] = CH_LF;
            end
        end else if (w_c == CH_TAB) begin
            if (w_cfg.tab_caret) begin
                w_ch[0] = CH_CARET;
                w_ch[1] = CH_I;
                w_nch   = 3'd2;
            end else begin
                w_ch[0] = CH_TAB;
            end
        end else if (w_cfg.ctrl_visible && (w_c < CH_CTRL_END || w_c >= CH_DEL)) begin
            if (w_c[7]) begin
                w_ch[0] = CH_M;
                w_ch[1] = CH_DASH;
                w_ch[2] = w_lo0;
                w_ch[3] = w_lo1;
                w_nch   = 3'd2 + {1'b0, w_nlo};
            end else begin
                w_ch[0] = w_lo0;
                w_ch[1] = w_lo1;
                w_nch   = {1'b0, w_nlo};
            end
        end else begin
            w_ch[0] = w_c;
        end
    end

    // digit i is shown when it or a higher digit is nonzero; digit 0 always
    always_comb begin
        w_shown[NUMBER_DIGITS-1] = (w_digits[(NUMBER_DIGITS-1)*4 +: 4] != 4'd0);
        for (int i = NUMBER_DIGITS - 2; i >= 0; i--) begin
            w_shown[i] = w_shown[i+1] || (w_digits[i*4 +: 4] != 4'd0) || (i == 0);
        end
        w_sig = SW'($countones(w_shown));
    end

    always_comb begin
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            n_buf[NUMBER_DIGITS-1-i] = w_shown[i] ? (CH_ZERO + {4'b0, w_digits[i*4 +: 4]})
                                                  : CH_SPACE;
        end
        n_buf[NUMBER_DIGITS]   = CH_SPACE;
        n_buf[NUMBER_DIGITS+1] = CH_SPACE;
        for (int k = 0; k < MAX_CHAR_OUT; k++) begin
            n_buf[NUMBER_DIGITS+2+k] = w_ch[k];
        end
        n_end = PW'(NUMBER_DIGITS + 2) + PW'(w_nch);
        if (!w_numbered) begin
            n_pos = PW'(NUMBER_DIGITS + 2);
        end else if (w_sig > SW'(MIN_NUM_WIDTH)) begin
            n_pos = PW'(NUMBER_DIGITS) - PW'(w_sig);
        end else begin
            n_pos = PW'(NUMBER_DIGITS - MIN_NUM_WIDTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_buf <= n_buf;
            r_end <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pos        <= '0;
            r_at_begin   <= 1'b1;
            r_blank_seen <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_pos  <= n_pos;
            end else if (w_out_acc) begin
                r_pos <= r_pos + PW'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_load) begin
                r_at_begin <= w_blank;
                if (r_at_begin) begin
                    r_blank_seen <= w_cfg.squeeze_on && w_blank;
                end
            end
        end
    end

    a_pos_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos < r_end))
        else $error("read position past end of run");

    a_no_accept_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_last) |-> !o_s_axis_tready)
        else $error("input taken while run not finished");

    a_run_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_last && !w_load) |=> !r_busy)
        else $error("serializer busy after last item of run");

    a_drop_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_drop) |=> (r_at_begin && r_blank_seen))
        else $error("dropped blank line changed line state");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import tla_pkg::*;

    localparam int unsigned NUM_DIGITS     = 10;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RAND_PHASES    = 6;
    localparam int unsigned PHASE_ITEMS    = 15;

    localparam logic [1:0] NUM_NONE = 2'd0;
    localparam logic [1:0] NUM_RSVD = 2'd3;

    localparam t_cfg CFG_PLAIN = '0;
    localparam t_cfg CFG_SHOW_ALL = '{number_mode: NUM_ALL, squeeze_on: 1'b0,
        eol_mark: 1'b1, tab_caret: 1'b1, ctrl_visible: 1'b1};
    localparam t_cfg CFG_SQUEEZE = '{number_mode: NUM_NONBLANK, squeeze_on: 1'b1,
        eol_mark: 1'b0, tab_caret: 1'b0, ctrl_visible: 1'b0};
    localparam t_cfg CFG_RSVD_MODE = '{number_mode: NUM_RSVD, squeeze_on: 1'b0,
        eol_mark: 1'b1, tab_caret: 1'b0, ctrl_visible: 1'b1};

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_char;

    typedef struct {
        t_cfg       cfg;
        logic [7:0] data;
        bit         chk;
        string      want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = '0;  // [7:0] data_byte
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [7:0]            o_m_axis_tdata;       // [7:0] out_byte
    logic                  o_m_axis_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state
    t_cfg       cfg_m = '0;
    logic [3:0] line_bcd [NUM_DIGITS];
    logic       blank_seen = 1'b0;
    logic       at_line_begin = 1'b1;
    t_out_char  expected_chars [$];

    t_stim_row  stim_tab [$];
    bit         typed_chk = 1'b0;
    string      typed_out = "";
    int         mismatches = 0;
    int         burst_left = 0;
    bit         gaps_on = 1'b0;
    logic [15:0] rdy_pat = '1;
    logic [3:0]  rdy_idx = '0;
    int unsigned idle_cycles = 0;

    text_line_annotator_top #(.NUMBER_DIGITS(NUM_DIGITS)) uut (.*);

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_axis_tready <= rdy_pat[rdy_idx];
        rdy_idx <= rdy_idx + 1'b1;
    end

    task automatic flag_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void emit_ch(input logic [7:0] ch);
        expected_chars.push_back('{ch: ch, last: 1'b0});
    endfunction

    function automatic void annotate_byte(input logic [7:0] c);
        int         i;
        int         sig;
        int         n0;
        logic       blank;
        logic       carry;
        logic       all9;
        logic [7:0] cc;
        n0 = expected_chars.size();
        blank = (c == CH_LF);
        if (at_line_begin) begin
            if (cfg_m.squeeze_on && blank) begin
                if (blank_seen) return;
                blank_seen = 1'b1;
            end else begin
                blank_seen = 1'b0;
            end
            if (cfg_m.number_mode == NUM_ALL || (cfg_m.number_mode == NUM_NONBLANK && !blank)) begin
                all9 = 1'b1;
                for (i = 0; i < NUM_DIGITS; i++) if (line_bcd[i] != 4'd9) all9 = 1'b0;
                carry = !all9;
                for (i = 0; i < NUM_DIGITS; i++) begin
                    if (carry) begin
                        if (line_bcd[i] >= 4'd9) begin
                            line_bcd[i] = 4'd0;
                        end else begin
                            line_bcd[i] = line_bcd[i] + 4'd1;
                            carry = 1'b0;
                        end
                    end
                end
                sig = 1;
                for (i = 0; i < NUM_DIGITS; i++) if (line_bcd[i] != 4'd0) sig = i + 1;
                for (i = sig; i < MIN_NUM_WIDTH; i++) emit_ch(CH_SPACE);
                for (i = sig - 1; i >= 0; i--) emit_ch(CH_ZERO + {4'd0, line_bcd[i]});
                emit_ch(CH_SPACE);
                emit_ch(CH_SPACE);
            end
            at_line_begin = 1'b0;
        end
        if (blank) begin
            if (cfg_m.eol_mark) emit_ch(CH_DOLLAR);
            emit_ch(CH_LF);
            at_line_begin = 1'b1;
        end else if (c == CH_TAB) begin
            if (cfg_m.tab_caret) begin
                emit_ch(CH_CARET);
                emit_ch(CH_I);
            end else begin
                emit_ch(CH_TAB);
            end
        end else if (cfg_m.ctrl_visible && (c < CH_CTRL_END || c >= CH_DEL)) begin
            cc = c;
            if (c[7]) begin
                emit_ch(CH_M);
                emit_ch(CH_DASH);
                cc[7] = 1'b0;
            end
            if (cc == CH_DEL) begin
                emit_ch(CH_CARET);
                emit_ch(CH_QMARK);
            end else if (cc < CH_CTRL_END) begin
                emit_ch(CH_CARET);
                emit_ch(cc + CH_AT);
            end else begin
                emit_ch(cc);
            end
        end else begin
            emit_ch(c);
        end
        if (expected_chars.size() > n0) expected_chars[expected_chars.size() - 1].last = 1'b1;
    endfunction

    // accept, predict, compare
    always @(posedge i_clk) begin
        int        n0;
        t_out_char want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                n0 = expected_chars.size();
                annotate_byte(i_s_axis_tdata);
                if (typed_chk) begin
                    while (expected_chars.size() > n0) void'(expected_chars.pop_back());
                    for (int i = 0; i < typed_out.len(); i++) emit_ch(typed_out[i]);
                    if (expected_chars.size() > n0)
                        expected_chars[expected_chars.size() - 1].last = 1'b1;
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_chars.size() == 0) begin
                    flag_mismatch($sformatf("unexpected output byte %02h last %0b",
                        o_m_axis_tdata, o_m_axis_tlast));
                end else begin
                    want = expected_chars.pop_front();
                    if (o_m_axis_tdata !== want.ch)
                        flag_mismatch($sformatf("out_byte %02h, want %02h",
                            o_m_axis_tdata, want.ch));
                    if (o_m_axis_tlast !== want.last)
                        flag_mismatch($sformatf("last_of_run %0b, want %0b (byte %02h)",
                            o_m_axis_tlast, want.last, want.ch));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic put_item(input logic [7:0] b, input bit chk, input string want);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(1, 6) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        typed_chk = chk;
        typed_out = want;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic settle_block();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_NUMBER_MODE:  cfg_m.number_mode = data[1:0];
            REG_SQUEEZE:      cfg_m.squeeze_on = data[0];
            REG_EOL_MARK:     cfg_m.eol_mark = data[0];
            REG_TAB_CARET:    cfg_m.tab_caret = data[0];
            REG_CTRL_VISIBLE: cfg_m.ctrl_visible = data[0];
            default: ;
        endcase
    endtask

    task automatic apb_read_check(input logic [2:0] idx);
        logic [CFG_DATA_W-1:0] got;
        logic [CFG_DATA_W-1:0] want;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_NUMBER_MODE: want = CFG_DATA_W'(cfg_m.number_mode);
            REG_SQUEEZE:     want = CFG_DATA_W'(cfg_m.squeeze_on);
            REG_EOL_MARK:    want = CFG_DATA_W'(cfg_m.eol_mark);
            REG_TAB_CARET:   want = CFG_DATA_W'(cfg_m.tab_caret);
            default:         want = CFG_DATA_W'(cfg_m.ctrl_visible);
        endcase
        if (got !== want)
            flag_mismatch($sformatf("reg %0d reads %08h, want %08h", idx, got, want));
    endtask

    task automatic set_cfg(input t_cfg c, input bit junk, input bit stray);
        logic [CFG_DATA_W-1:0] w;
        logic [2:0]            idx;
        settle_block();
        for (int k = REG_NUMBER_MODE; k <= REG_CTRL_VISIBLE; k++) begin
            idx = k[2:0];
            w = junk ? CFG_DATA_W'($urandom) : '0;
            case (idx)
                REG_NUMBER_MODE: w[1:0] = c.number_mode;
                REG_SQUEEZE:     w[0] = c.squeeze_on;
                REG_EOL_MARK:    w[0] = c.eol_mark;
                REG_TAB_CARET:   w[0] = c.tab_caret;
                default:         w[0] = c.ctrl_visible;
            endcase
            apb_write(idx, w);
        end
        // unmapped index, must not disturb anything
        if (stray)
            apb_write(3'($urandom_range(int'(REG_CTRL_VISIBLE) + 1, 7)),
                CFG_DATA_W'($urandom));
        for (int k = REG_NUMBER_MODE; k <= REG_CTRL_VISIBLE; k++) apb_read_check(k[2:0]);
    endtask

    function automatic void add_row(input t_cfg c, input logic [7:0] b, input bit chk,
                                    input string want);
        t_stim_row r;
        r.cfg = c;
        r.data = b;
        r.chk = chk;
        r.want = want;
        stim_tab.push_back(r);
    endfunction

    initial begin
        t_cfg       c;
        int         n;
        int         len;
        logic [7:0] ch;

        for (int i = 0; i < NUM_DIGITS; i++) line_bcd[i] = 4'd0;

        add_row(CFG_PLAIN, "A", 1'b1, "A");
        add_row(CFG_PLAIN, 8'h00, 1'b0, "");
        add_row(CFG_PLAIN, 8'hFF, 1'b0, "");
        add_row(CFG_PLAIN, CH_TAB, 1'b1, "\t");
        add_row(CFG_PLAIN, CH_LF, 1'b1, "\n");
        add_row(CFG_SHOW_ALL, 8'h00, 1'b1, "     1  ^@");
        add_row(CFG_SHOW_ALL, CH_TAB, 1'b1, "^I");
        add_row(CFG_SHOW_ALL, CH_DEL, 1'b1, "^?");
        add_row(CFG_SHOW_ALL, 8'h80, 1'b1, "M-^@");
        add_row(CFG_SHOW_ALL, 8'hFF, 1'b1, "M-^?");
        add_row(CFG_SHOW_ALL, 8'h1F, 1'b1, "^_");
        add_row(CFG_SHOW_ALL, 8'hA0, 1'b1, "M- ");
        add_row(CFG_SHOW_ALL, " ", 1'b1, " ");
        add_row(CFG_SHOW_ALL, "~", 1'b1, "~");
        add_row(CFG_SHOW_ALL, CH_LF, 1'b1, "$\n");
        add_row(CFG_SQUEEZE, CH_LF, 1'b1, "\n");
        add_row(CFG_SQUEEZE, CH_LF, 1'b1, "");
        add_row(CFG_SQUEEZE, CH_LF, 1'b1, "");
        add_row(CFG_SQUEEZE, "x", 1'b1, "     2  x");
        add_row(CFG_SQUEEZE, CH_LF, 1'b1, "\n");
        add_row(CFG_SQUEEZE, 8'h80, 1'b0, "");
        add_row(CFG_SQUEEZE, CH_LF, 1'b0, "");
        add_row(CFG_RSVD_MODE, CH_LF, 1'b1, "$\n");
        add_row(CFG_RSVD_MODE, CH_TAB, 1'b1, "\t");
        add_row(CFG_RSVD_MODE, "Z", 1'b1, "Z");
        add_row(CFG_RSVD_MODE, CH_LF, 1'b1, "$\n");

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = REG_NUMBER_MODE; k <= REG_CTRL_VISIBLE; k++) apb_read_check(k[2:0]);

        gaps_on = 1'b1;
        rdy_pat = 16'hB6D3;
        for (int r = 0; r < stim_tab.size(); r++) begin
            if (r == 0 || stim_tab[r].cfg != stim_tab[r - 1].cfg)
                set_cfg(stim_tab[r].cfg, r != 0, 1'b0);
            put_item(stim_tab[r].data, stim_tab[r].chk, stim_tab[r].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            c = t_cfg'($urandom);
            if (ph == 0) c = '1;
            else if (ph == 1) c = '0;
            gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            rdy_pat = (ph == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            set_cfg(c, 1'($urandom_range(0, 1)), ph == 2);
            n = 0;
            while (n < PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        repeat ($urandom_range(1, 3)) begin
                            put_item(CH_LF, 1'b0, "");
                            n++;
                        end
                    end
                    2: begin
                        repeat ($urandom_range(1, 3)) begin
                            put_item(8'($urandom), 1'b0, "");
                            n++;
                        end
                    end
                    default: begin
                        len = $urandom_range(0, 8);
                        repeat (len) begin
                            case ($urandom_range(0, 15))
                                0:       ch = CH_TAB;
                                1:       ch = 8'($urandom_range(0, int'(CH_CTRL_END) - 1));
                                2:       ch = CH_DEL;
                                3, 4:    ch = 8'($urandom_range(128, 255));
                                default: ch = 8'($urandom_range(int'(CH_SPACE),
                                                               int'(CH_DEL) - 1));
                            endcase
                            put_item(ch, 1'b0, "");
                            n++;
                        end
                        put_item(CH_LF, 1'b0, "");
                        n++;
                    end
                endcase
            end
        end

        settle_block();
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
src/tla_pkg.sv
src/tla_cfg_regs.sv
src/tla_bcd_counter.sv
src/text_line_annotator_top.sv
tb/tb_top.sv
